[rtl/fractional_feedback_delay_line_top_macros.svh]
// assertion macros for the fractional feedback delay line
// used by the top level only, compiled out when SYNTHESIS is defined
`ifndef FRACTIONAL_FEEDBACK_DELAY_LINE_TOP_MACROS_SVH
`define FRACTIONAL_FEEDBACK_DELAY_LINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FFDL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffdl assertion failed");
`define FFDL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffdl assertion failed");
`else
`define FFDL_ASSERT_IMP(label, clk, rst, ante, cons)
`define FFDL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/ffdl_pkg.sv]
// shared types, constants and helpers of the fractional feedback delay line
// no dependencies
package ffdl_pkg;

   localparam int DEPTH_DEFAULT       = 65536;
   localparam int CHANNELS_DEFAULT    = 2;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int DELAY_BITS   = 24;
   localparam int GAIN_BITS    = 16;
   localparam int FRAC_BITS    = 8;
   localparam int FRAC_ONE     = 1 << FRAC_BITS;
   localparam int ECHO_SHIFT   = 23;
   localparam int ECHO_ROUND   = 1 << (ECHO_SHIFT - 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DELAY_BITS-1:0] DELAY_MIN   = 24'd26;
   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 24'd1228800;
   localparam logic [GAIN_BITS-1:0]  GAIN_ONE    = 16'd32768;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 16'd0;

   typedef enum logic [2:0] {
      REG_DELAY_LENGTH  = 3'd0,
      REG_FEEDBACK_GAIN = 3'd1,
      REG_RECIRCULATE   = 3'd2,
      REG_TAKE_INPUT    = 3'd3,
      REG_INVERT_ECHO   = 3'd4,
      REG_KEEP_DRY      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic recirculate;
      logic take_input;
      logic invert_echo;
      logic keep_dry;
   } echo_mode_type;

   typedef struct packed {
      logic [DELAY_BITS-1:0] delay_length;
      logic [GAIN_BITS-1:0]  feedback_gain;
      echo_mode_type         mode;
   } echo_cfg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic pop;
      logic mem_write;
   } back_status_type;

   localparam echo_mode_type MODE_RESET = '{
      recirculate: 1'b1, take_input: 1'b1, invert_echo: 1'b0, keep_dry: 1'b1
   };

   function automatic int chan_bits(input int channels);
      return (channels > 1) ? $clog2(channels) : 1;
   endfunction

   function automatic int item_bits(input int sample_bits, input int addr_bits,
                                    input int chan_width);
      return 1 + chan_width + sample_bits + addr_bits + FRAC_BITS + GAIN_BITS +
             $bits(echo_mode_type);
   endfunction

endpackage

[rtl/ffdl_if.sv]
// request and response channel interfaces of the fractional feedback delay line
// depends on ffdl_pkg
interface ffdl_req_if #(
   parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEFAULT
) ();
   logic                          valid;
   logic                          ready;
   logic                          channel;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source(output valid, channel, sample_in, input ready);
   modport sink(input valid, channel, sample_in, output ready);
endinterface

interface ffdl_rsp_if #(
   parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEFAULT
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          out_channel;

   modport source(output valid, sample_out, out_channel, input ready);
   modport sink(input valid, sample_out, out_channel, output ready);
endinterface

[rtl/fractional_feedback_delay_line_top.sv]
// Fractional feedback delay line (echo with interpolated delay taps).
// Request channel req_bus carries one beat per sample: channel and sample_in.
// Response channel rsp_bus returns one beat per request: sample_out and
// out_channel, in request order. Both use valid/ready; a beat moves when both
// are high. Registers sit behind the csr_ port; the user must write them only
// when idle, and the block does not enforce it. A two-entry queue separates
// the front end from the back end, so requests are taken while the back end
// works and while a response beat waits. The back end handles one sample at
// a time: tap address, dual-port memory read, blend multiply, gain multiply,
// write-back. The response beat is registered at write-back.
// Reset clears the write pointers and per-channel wrap flags; memory entries
// never written since reset read as zero through those flags, so no clearing
// pass is run and requests are taken right after reset.
// When rsp ready stays low, the finished beat is held, the back end waits in
// its write step, the queue fills and then req ready drops.
// Depends on ffdl_pkg, ffdl_if, ffdl_csr, ffdl_front, ffdl_queue, ffdl_back.
`include "fractional_feedback_delay_line_top_macros.svh"

module fractional_feedback_delay_line_top #(
   parameter int DEPTH       = ffdl_pkg::DEPTH_DEFAULT,
   parameter int CHANNELS    = ffdl_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   ffdl_req_if.sink                           req_bus,
   ffdl_rsp_if.source                         rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ffdl_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ffdl_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ffdl_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import ffdl_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = chan_bits(CHANNELS);
   localparam int IW = item_bits(SAMPLE_BITS, AW, CW);

   echo_cfg_type     cfg;
   queue_status_type q_stat;
   back_status_type  back_stat;
   logic             push, pop;
   logic [IW-1:0]    push_item, head_item;

   ffdl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ffdl_front #(
      .DEPTH       (DEPTH),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .req_bus (req_bus),
      .cfg     (cfg),
      .q_stat  (q_stat),
      .push    (push),
      .item    (push_item)
   );

   ffdl_queue #(
      .W (IW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_item),
      .pop       (pop),
      .head      (head_item),
      .q_stat    (q_stat)
   );

   ffdl_back #(
      .DEPTH       (DEPTH),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head      (head_item),
      .pop       (pop),
      .back_stat (back_stat),
      .rsp_bus   (rsp_bus)
   );

   `FFDL_ASSERT_IMP(a_pop_needs_item, clock, reset, back_stat.pop, !q_stat.empty)
   `FFDL_ASSERT_NXT(a_one_item_at_a_time, clock, reset, back_stat.pop, !back_stat.pop)
   `FFDL_ASSERT_NXT(a_write_gives_beat, clock, reset, back_stat.mem_write, rsp_bus.valid)
   `FFDL_ASSERT_IMP(a_full_stalls_req, clock, reset, q_stat.full, !req_bus.ready)

endmodule

[rtl/ffdl_csr.sv]
// configuration registers behind the apb-style port
// depends on ffdl_pkg
module ffdl_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ffdl_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [ffdl_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [ffdl_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output ffdl_pkg::echo_cfg_type                cfg
);
   import ffdl_pkg::*;

   logic [DELAY_BITS-1:0] delay_ff, delay_in;
   logic [GAIN_BITS-1:0]  gain_ff, gain_in;
   echo_mode_type         mode_ff, mode_in;
   logic                  wr;
   reg_index_type         index;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      delay_in = delay_ff;
      gain_in  = gain_ff;
      mode_in  = mode_ff;
      if (wr) begin
         case (index)
            REG_DELAY_LENGTH:  delay_in = csr_pwdata[DELAY_BITS-1:0];
            REG_FEEDBACK_GAIN: gain_in = csr_pwdata[GAIN_BITS-1:0];
            REG_RECIRCULATE:   mode_in.recirculate = csr_pwdata[0];
            REG_TAKE_INPUT:    mode_in.take_input = csr_pwdata[0];
            REG_INVERT_ECHO:   mode_in.invert_echo = csr_pwdata[0];
            REG_KEEP_DRY:      mode_in.keep_dry = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_DELAY_LENGTH:  csr_prdata = CSR_DATA_BITS'(delay_ff);
         REG_FEEDBACK_GAIN: csr_prdata = CSR_DATA_BITS'(gain_ff);
         REG_RECIRCULATE:   csr_prdata = CSR_DATA_BITS'(mode_ff.recirculate);
         REG_TAKE_INPUT:    csr_prdata = CSR_DATA_BITS'(mode_ff.take_input);
         REG_INVERT_ECHO:   csr_prdata = CSR_DATA_BITS'(mode_ff.invert_echo);
         REG_KEEP_DRY:      csr_prdata = CSR_DATA_BITS'(mode_ff.keep_dry);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
         gain_ff  <= GAIN_RESET;
         mode_ff  <= MODE_RESET;
      end else begin
         delay_ff <= delay_in;
         gain_ff  <= gain_in;
         mode_ff  <= mode_in;
      end
   end

   assign cfg.delay_length  = delay_ff;
   assign cfg.feedback_gain = gain_ff;
   assign cfg.mode          = mode_ff;

endmodule

[rtl/ffdl_front.sv]
// front end: accepts request beats, clamps delay and gain, picks the channel memory
// depends on ffdl_pkg and ffdl_if
module ffdl_front #(
   parameter int DEPTH       = ffdl_pkg::DEPTH_DEFAULT,
   parameter int CHANNELS    = ffdl_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEFAULT,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = ffdl_pkg::chan_bits(CHANNELS),
   localparam int IW = ffdl_pkg::item_bits(SAMPLE_BITS, AW, CW)
) (
   ffdl_req_if.sink                  req_bus,
   input  ffdl_pkg::echo_cfg_type    cfg,
   input  ffdl_pkg::queue_status_type q_stat,
   output logic                      push,
   output logic [IW-1:0]             item
);
   import ffdl_pkg::*;

   localparam logic [31:0] DMAX = 32'((DEPTH - 2) * FRAC_ONE);

   logic [31:0]          dly_ext, dly_cl;
   logic [GAIN_BITS-1:0] gain_cl;
   logic [CW-1:0]        ch;

   assign req_bus.ready = !q_stat.full;
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      dly_ext = 32'(cfg.delay_length);
      if (dly_ext < 32'(DELAY_MIN)) begin
         dly_cl = 32'(DELAY_MIN);
      end else if (dly_ext > DMAX) begin
         dly_cl = DMAX;
      end else begin
         dly_cl = dly_ext;
      end
      gain_cl = (cfg.feedback_gain > GAIN_ONE) ? GAIN_ONE : cfg.feedback_gain;
      ch = (CHANNELS > 1) ? CW'(req_bus.channel) : '0;
   end

   assign item = {req_bus.channel, ch, req_bus.sample_in,
                  dly_cl[AW+FRAC_BITS-1:FRAC_BITS], dly_cl[FRAC_BITS-1:0],
                  gain_cl, cfg.mode};

endmodule

[rtl/ffdl_queue.sv]
// short queue of classified items between front and back end
// depends on ffdl_pkg
module ffdl_queue #(
   parameter int W = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [W-1:0]               push_data,
   input  logic                       pop,
   output logic [W-1:0]               head,
   output ffdl_pkg::queue_status_type q_stat
);
   import ffdl_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [W-1:0]  slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == NW'(QUEUE_DEPTH));

endmodule

[rtl/ffdl_back.sv]
// back end: delay memory, two-tap interpolation, feedback gain, mix and write-back
// depends on ffdl_pkg and ffdl_if
module ffdl_back #(
   parameter int DEPTH       = ffdl_pkg::DEPTH_DEFAULT,
   parameter int CHANNELS    = ffdl_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEFAULT,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = ffdl_pkg::chan_bits(CHANNELS),
   localparam int IW = ffdl_pkg::item_bits(SAMPLE_BITS, AW, CW)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ffdl_pkg::queue_status_type q_stat,
   input  logic [IW-1:0]              head,
   output logic                       pop,
   output ffdl_pkg::back_status_type  back_stat,
   ffdl_rsp_if.source                 rsp_bus
);
   import ffdl_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int MAW = $clog2(CHANNELS * DEPTH);
   localparam int PRW = SB + FRAC_BITS + 2;
   localparam int BW  = PRW + 1;
   localparam int GW  = GAIN_BITS + 1;
   localparam int XW  = BW + GW;
   localparam int EW  = SB + 1;
   localparam int MW  = SB + 2;
   localparam logic [AW:0]  DEPTH_X = (AW + 1)'(DEPTH);
   localparam logic [MAW:0] DEPTH_M = (MAW + 1)'(DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_BLEND = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_WRITE = 5'b10000
   } back_state_type;

   function automatic logic signed [SB-1:0] sat(input logic signed [MW-1:0] v);
      if (v[MW-1:SB-1] == '0 || v[MW-1:SB-1] == '1) begin
         return v[SB-1:0];
      end else if (v[MW-1]) begin
         return {1'b1, {(SB - 1){1'b0}}};
      end else begin
         return {1'b0, {(SB - 1){1'b1}}};
      end
   endfunction

   // head item fields
   logic                 h_chf;
   logic [CW-1:0]        h_ch;
   logic signed [SB-1:0] h_x;
   logic [AW-1:0]        h_a;
   logic [FRAC_BITS-1:0] h_f;
   logic [GAIN_BITS-1:0] h_gain;
   echo_mode_type        h_mode;

   assign {h_chf, h_ch, h_x, h_a, h_f, h_gain, h_mode} = head;

   back_state_type       state_ff, state_in;
   logic                 chf_ff;
   logic [CW-1:0]        ch_ff;
   logic signed [SB-1:0] x_ff;
   logic [FRAC_BITS-1:0] f_ff;
   logic [GAIN_BITS-1:0] gain_ff;
   echo_mode_type        mode_ff;
   logic [AW-1:0]        idx0_ff, idx1_ff, idx0_in, idx1_in;
   logic                 v0_ff, v1_ff, v0_in, v1_in;
   logic [MAW-1:0]       base_ff, base_in;
   logic signed [SB-1:0] rd0_ff, rd1_ff;
   logic signed [BW-1:0] blend_ff, blend_in;
   logic signed [XW-1:0] prod_ff, prod_in;
   logic [AW-1:0]        wp_ff [CHANNELS];
   logic                 wrap_ff [CHANNELS];
   logic [AW-1:0]        wp_in;
   logic                 wrap_in;
   logic                 out_valid_ff, out_valid_in;
   logic signed [SB-1:0] out_sample_ff;
   logic                 out_ch_ff;

   logic signed [SB-1:0] mem [CHANNELS * DEPTH];

   logic                 mem_we;
   logic [MAW-1:0]       addr0, addr1, waddr;
   logic [AW:0]          back0, back1, wpx;
   logic [AW-1:0]        wp_h;
   logic signed [SB-1:0] t0, t1;
   logic [FRAC_BITS:0]   w0;
   logic signed [FRAC_BITS+1:0] ws0, ws1;
   logic signed [PRW-1:0] p0, p1;
   logic signed [GW-1:0] gs;
   logic signed [XW-1:0] rnd, shf;
   logic signed [EW-1:0] echo_raw, echo;
   logic signed [MW-1:0] mix;
   logic signed [SB-1:0] mixed, echo_s, wdata, out_val;

   // sequencer
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      mem_we   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_BLEND;
         ST_BLEND: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_WRITE;
         ST_WRITE: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               mem_we   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // tap positions behind the write pointer
   always_comb begin
      wp_h    = wp_ff[h_ch];
      wpx     = {1'b0, wp_h};
      back0   = (AW + 1)'(h_a) + (AW + 1)'(1);
      back1   = (AW + 1)'(h_a) + (AW + 1)'(2);
      idx0_in = (wpx >= back0) ? AW'(wpx - back0) : AW'(wpx + DEPTH_X - back0);
      idx1_in = (wpx >= back1) ? AW'(wpx - back1) : AW'(wpx + DEPTH_X - back1);
      v0_in   = wrap_ff[h_ch] || (idx0_in < wp_h);
      v1_in   = wrap_ff[h_ch] || (idx1_in < wp_h);
      base_in = MAW'((MAW + 1)'(h_ch) * DEPTH_M);
   end

   assign addr0 = base_ff + MAW'(idx0_ff);
   assign addr1 = base_ff + MAW'(idx1_ff);
   assign waddr = base_ff + MAW'(wp_ff[ch_ff]);

   // interpolation and gain
   always_comb begin
      t0       = v0_ff ? rd0_ff : '0;
      t1       = v1_ff ? rd1_ff : '0;
      w0       = (FRAC_BITS + 1)'(FRAC_ONE) - (FRAC_BITS + 1)'(f_ff);
      ws0      = $signed({1'b0, w0});
      ws1      = $signed({2'b00, f_ff});
      p0       = t0 * ws0;
      p1       = t1 * ws1;
      blend_in = BW'(p0) + BW'(p1);
      gs       = $signed({1'b0, gain_ff});
      prod_in  = blend_ff * gs;
   end

   // rounding, mix and saturation
   always_comb begin
      rnd      = prod_ff + XW'(ECHO_ROUND);
      shf      = rnd >>> ECHO_SHIFT;
      echo_raw = shf[EW-1:0];
      echo     = mode_ff.invert_echo ? -echo_raw : echo_raw;
      mix      = MW'(x_ff) + MW'(echo);
      mixed    = sat(mix);
      echo_s   = sat(MW'(echo));
      if (mode_ff.take_input) begin
         wdata = mode_ff.recirculate ? mixed : x_ff;
      end else begin
         wdata = echo_s;
      end
      out_val      = mode_ff.keep_dry ? mixed : echo_s;
      wp_in        = (wp_ff[ch_ff] == AW'(DEPTH - 1)) ? '0 : wp_ff[ch_ff] + 1'b1;
      wrap_in      = wrap_ff[ch_ff] || (wp_ff[ch_ff] == AW'(DEPTH - 1));
      out_valid_in = mem_we ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i]   <= '0;
            wrap_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (mem_we) begin
            wp_ff[ch_ff]   <= wp_in;
            wrap_ff[ch_ff] <= wrap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         chf_ff  <= h_chf;
         ch_ff   <= h_ch;
         x_ff    <= h_x;
         f_ff    <= h_f;
         gain_ff <= h_gain;
         mode_ff <= h_mode;
         idx0_ff <= idx0_in;
         idx1_ff <= idx1_in;
         v0_ff   <= v0_in;
         v1_ff   <= v1_in;
         base_ff <= base_in;
      end
      if (state_ff == ST_BLEND) begin
         blend_ff <= blend_in;
      end
      if (state_ff == ST_SCALE) begin
         prod_ff <= prod_in;
      end
      if (mem_we) begin
         out_sample_ff <= out_val;
         out_ch_ff     <= chf_ff;
      end
   end

   // delay memory, two read ports and one write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (state_ff == ST_READ) begin
         rd0_ff <= mem[addr0];
         rd1_ff <= mem[addr1];
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.sample_out  = out_sample_ff;
   assign rsp_bus.out_channel = out_ch_ff;
   assign back_stat.pop       = pop;
   assign back_stat.mem_write = mem_we;

endmodule

[sim/tb_fractional_feedback_delay_line_top.sv]
// self-checking testbench of the fractional feedback delay line top level
// predicts each response beat from its own per-channel delay memory and settings
// depends on ffdl_pkg, ffdl_if and fractional_feedback_delay_line_top
`timescale 1ns / 100ps

module tb_fractional_feedback_delay_line_top;
   import ffdl_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int CHANNELS       = CHANNELS_DEFAULT;
   localparam int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT;
   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_SAMPLES  = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int MAX_PRINTED    = 40;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          out_channel;
   } echo_beat_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   ffdl_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   ffdl_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   fractional_feedback_delay_line_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the block state and settings
   bit signed [SAMPLE_BITS-1:0] delay_mem [CHANNELS][DEPTH];
   int unsigned                 write_ptr [CHANNELS];
   echo_cfg_type                echo_cfg;

   echo_beat_type expected_beats [$];
   bit            send_steady;
   bit            take_steady;
   int            samples_sent;
   int            beats_checked;
   int            settings_applied;
   int            mismatch_count;
   int            quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clip_sample(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // sample written 'back' writes ago on one channel
   function automatic longint stored_sample(input int slot, input int back);
      return longint'(delay_mem[slot][(write_ptr[slot] + DEPTH - (back % DEPTH)) % DEPTH]);
   endfunction

   function automatic echo_beat_type next_echo_beat(input bit ch,
                                                    input logic signed [SAMPLE_BITS-1:0] x_in);
      longint        x;
      longint        delay;
      longint        blend;
      longint        gain;
      longint        echo;
      longint        mixed;
      longint        stored;
      int            whole;
      int            frac;
      int            slot;
      echo_beat_type beat;
      x = x_in;
      slot = int'(ch) % CHANNELS;
      delay = echo_cfg.delay_length;
      if (delay < longint'(DELAY_MIN)) delay = DELAY_MIN;
      if (delay > longint'(DEPTH - 2) * FRAC_ONE) delay = longint'(DEPTH - 2) * FRAC_ONE;
      whole = int'(delay >> FRAC_BITS);
      frac = int'(delay & (FRAC_ONE - 1));
      blend = stored_sample(slot, whole + 1) * (FRAC_ONE - frac)
            + stored_sample(slot, whole + 2) * frac;
      gain = (echo_cfg.feedback_gain > GAIN_ONE) ? longint'(GAIN_ONE)
                                                 : longint'(echo_cfg.feedback_gain);
      echo = (blend * gain + ECHO_ROUND) >>> ECHO_SHIFT;
      if (echo_cfg.mode.invert_echo) echo = -echo;
      mixed = clip_sample(x + echo);
      if (!echo_cfg.mode.take_input) stored = clip_sample(echo);
      else if (echo_cfg.mode.recirculate) stored = mixed;
      else stored = x;
      delay_mem[slot][write_ptr[slot]] = SAMPLE_BITS'(stored);
      write_ptr[slot] = (write_ptr[slot] + 1) % DEPTH;
      beat.sample_out = SAMPLE_BITS'(echo_cfg.mode.keep_dry ? mixed : clip_sample(echo));
      beat.out_channel = ch;
      return beat;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_BITS'(SAMPLE_MAX);
         1: return SAMPLE_BITS'(SAMPLE_MIN);
         2, 3: return SAMPLE_BITS'($urandom_range(0, 1023) - 512);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [DELAY_BITS-1:0] draw_delay();
      case ($urandom_range(0, 9))
         0: return DELAY_BITS'($urandom_range(0, DELAY_MIN - 1));
         1: return DELAY_BITS'((DEPTH - 2) * FRAC_ONE + $urandom_range(0, FRAC_ONE - 1));
         2: return DELAY_BITS'($urandom_range(24'hFF0000, 24'hFFFFFF));
         3: return DELAY_BITS'($urandom);
         default: return DELAY_BITS'($urandom_range(DELAY_MIN, 25 * FRAC_ONE - 1));
      endcase
   endfunction

   function automatic logic [GAIN_BITS-1:0] draw_gain();
      case ($urandom_range(0, 4))
         0: return GAIN_ONE;
         1: return GAIN_BITS'($urandom_range(GAIN_ONE, 16'hFFFF));
         2: return GAIN_BITS'($urandom_range(GAIN_ONE - 512, GAIN_ONE));
         default: return GAIN_BITS'($urandom_range(0, GAIN_ONE));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) $display("MISMATCH %s", msg);
      mismatch_count++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_DELAY_LENGTH:  echo_cfg.delay_length = data[DELAY_BITS-1:0];
         REG_FEEDBACK_GAIN: echo_cfg.feedback_gain = data[GAIN_BITS-1:0];
         REG_RECIRCULATE:   echo_cfg.mode.recirculate = data[0];
         REG_TAKE_INPUT:    echo_cfg.mode.take_input = data[0];
         REG_INVERT_ECHO:   echo_cfg.mode.invert_echo = data[0];
         REG_KEEP_DRY:      echo_cfg.mode.keep_dry = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [DELAY_BITS-1:0] delay,
                               input logic [GAIN_BITS-1:0] gain,
                               input bit recirc, input bit take, input bit invert,
                               input bit dry);
      csr_write(REG_DELAY_LENGTH, CSR_DATA_BITS'(delay));
      csr_write(REG_FEEDBACK_GAIN, CSR_DATA_BITS'(gain));
      csr_write(REG_RECIRCULATE, CSR_DATA_BITS'(recirc));
      csr_write(REG_TAKE_INPUT, CSR_DATA_BITS'(take));
      csr_write(REG_INVERT_ECHO, CSR_DATA_BITS'(invert));
      csr_write(REG_KEEP_DRY, CSR_DATA_BITS'(dry));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   task automatic send_sample(input bit ch, input logic signed [SAMPLE_BITS-1:0] x);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.channel <= ch;
      req_bus.sample_in <= x;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_beats.push_back(next_echo_beat(ch, x));
      samples_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
   endtask

   // gain is zero after reset, so the output follows the input
   task automatic test_reset_values();
      send_sample(1'b0, SAMPLE_BITS'(SAMPLE_MAX));
      send_sample(1'b1, SAMPLE_BITS'(SAMPLE_MIN));
      send_sample(1'b0, '0);
      send_sample(1'b1, '1);
   endtask

   task automatic test_full_scale_feedback();
      drain_results();
      apply_config(DELAY_MIN, GAIN_ONE, 1'b1, 1'b1, 1'b0, 1'b1);
      repeat (3) begin
         send_sample(1'b0, SAMPLE_BITS'(SAMPLE_MAX));
         send_sample(1'b1, SAMPLE_BITS'(SAMPLE_MIN));
      end
   endtask

   task automatic test_special_cases();
      // delay below minimum, gain above unity, inverted echo only
      drain_results();
      apply_config('0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0);
      send_sample(1'b0, SAMPLE_BITS'(SAMPLE_MIN));
      send_sample(1'b0, SAMPLE_BITS'(SAMPLE_MIN));
      send_sample(1'b1, SAMPLE_BITS'(SAMPLE_MAX));
      // delay above maximum reads the oldest entries
      drain_results();
      apply_config('1, GAIN_ONE, 1'b1, 1'b1, 1'b0, 1'b1);
      send_sample(1'b0, SAMPLE_BITS'(1234));
      send_sample(1'b1, '1);
      // single echo with a fractional tap
      drain_results();
      apply_config(DELAY_BITS'(2 * FRAC_ONE + FRAC_ONE / 2), GAIN_ONE / 2,
                   1'b0, 1'b1, 1'b0, 1'b1);
      send_sample(1'b0, SAMPLE_BITS'(SAMPLE_MAX));
      send_sample(1'b0, SAMPLE_BITS'(-20000));
      send_sample(1'b1, SAMPLE_BITS'(20000));
      // input off: only the inverted echo goes back into memory
      drain_results();
      apply_config(DELAY_BITS'(FRAC_ONE), GAIN_ONE, 1'b1, 1'b0, 1'b1, 1'b1);
      send_sample(1'b0, SAMPLE_BITS'(SAMPLE_MIN));
      send_sample(1'b1, SAMPLE_BITS'(SAMPLE_MAX));
      send_sample(1'b0, SAMPLE_BITS'(100));
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         send_steady = ($urandom_range(0, 3) == 0);
         take_steady = ($urandom_range(0, 3) == 0);
         apply_config(draw_delay(), draw_gain(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            // let the pipeline run empty once in the middle of a phase
            if (phase == RANDOM_PHASES / 2 && n == PHASE_SAMPLES / 2) drain_results();
            send_sample(1'($urandom_range(0, 1)), draw_sample());
         end
      end
      send_steady = 1'b0;
      take_steady = 1'b0;
   endtask

   initial begin : response_check
      int            stall;
      echo_beat_type want;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = take_steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         beats_checked++;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("beat %0d not expected: sample_out %0d out_channel %0d",
                                      beats_checked, rsp_bus.sample_out, rsp_bus.out_channel));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_bus.sample_out !== want.sample_out)
               report_mismatch($sformatf("beat %0d sample_out %0d, expected %0d",
                                         beats_checked, rsp_bus.sample_out, want.sample_out));
            if (rsp_bus.out_channel !== want.out_channel)
               report_mismatch($sformatf("beat %0d out_channel %0d, expected %0d",
                                         beats_checked, rsp_bus.out_channel,
                                         want.out_channel));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, expected_beats.size());
         $display("tb_fractional_feedback_delay_line_top NOT OK");
         $finish;
      end
   end

   initial begin
      echo_cfg = '{delay_length: DELAY_RESET, feedback_gain: GAIN_RESET, mode: MODE_RESET};
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.channel <= 1'b0;
      req_bus.sample_in <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_full_scale_feedback();
      test_special_cases();
      test_random_settings();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d samples on both channels under %0d register settings",
               samples_sent, settings_applied);
      $display("%0d response beats checked, %0d mismatches", beats_checked, mismatch_count);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("tb_fractional_feedback_delay_line_top OK");
      end else begin
         $display("tb_fractional_feedback_delay_line_top NOT OK");
      end
      $finish;
   end

endmodule

[fractional_feedback_delay_line_top.f]
+incdir+rtl
rtl/ffdl_pkg.sv
rtl/ffdl_if.sv
rtl/ffdl_csr.sv
rtl/ffdl_front.sv
rtl/ffdl_queue.sv
rtl/ffdl_back.sv
rtl/fractional_feedback_delay_line_top.sv
sim/tb_fractional_feedback_delay_line_top.sv
